@@ src/bdvb_pkg.sv @@
// Shared types, constants and helper functions of the bounded-delay value buffer.
package bdvb_pkg;

  localparam int BufferDepth = 16;
  localparam int ValueBits   = 16;
  localparam int SlackBits   = 8;
  localparam int OccW        = $clog2(BufferDepth + 1);
  localparam int CmpW        = (OccW > 5) ? OccW : 5;
  localparam int DropW       = 9;

  typedef enum logic {
    ReqArrival = 1'b0,
    ReqTick    = 1'b1
  } req_e;

  typedef enum logic [2:0] {
    OpHold,
    OpInsert,
    OpReplace,
    OpDecrement,
    OpCompact,
    OpPop
  } cell_op_e;

  typedef struct packed {
    logic                 valid;
    logic [ValueBits-1:0] value;
    logic [SlackBits-1:0] slack;
  } entry_t;

  typedef struct packed {
    cell_op_e             op;
    logic [ValueBits-1:0] value;
    logic [SlackBits-1:0] slack;
  } cell_ctl_t;

  typedef struct packed {
    logic                 any_lower;
    logic                 any_gap;
    logic                 head_valid;
    logic [ValueBits-1:0] head_value;
    logic [OccW-1:0]      occ_found;
  } chain_stat_t;

  localparam entry_t EntryTop  = '{valid: 1'b1, value: '1, slack: '1};
  localparam entry_t EntryNone = '{valid: 1'b0, value: '0, slack: '0};

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? '1 : s[47:0];
  endfunction

endpackage

@@ src/bdvb_cell.sv @@
// One cell of the sorted entry chain, holding a single buffer entry.
module bdvb_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bdvb_pkg::cell_ctl_t ctl_i,
  input  bdvb_pkg::entry_t   left_i,
  input  bdvb_pkg::entry_t   right_i,
  output bdvb_pkg::entry_t   entry_o,
  output logic               lower_o,
  output logic               gap_o,
  output logic               bnd_o
);
  import bdvb_pkg::*;

  entry_t               entry_q, entry_d, new_entry;
  logic                 valid_q;
  logic [ValueBits-1:0] value_q;
  logic [SlackBits-1:0] slack_q;
  logic                 ge_own, ge_left;

  function automatic logic below_new(input entry_t e, input cell_ctl_t c);
    return (e.value < c.value) || ((e.value == c.value) && (e.slack < c.slack));
  endfunction

  assign entry_q   = '{valid: valid_q, value: value_q, slack: slack_q};
  assign new_entry = '{valid: 1'b1, value: ctl_i.value, slack: ctl_i.slack};
  assign ge_own    = entry_q.valid && !below_new(entry_q, ctl_i);
  assign ge_left   = left_i.valid && !below_new(left_i, ctl_i);

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      OpHold: entry_d = entry_q;
      OpInsert: begin
        if (ge_own) begin
          entry_d = entry_q;
        end else if (ge_left) begin
          entry_d = new_entry;
        end else begin
          entry_d = left_i;
        end
      end
      OpReplace: begin
        if (ge_own) begin
          entry_d = entry_q;
        end else if (!entry_q.valid && left_i.valid) begin
          entry_d = entry_q;
        end else if (ge_left) begin
          entry_d = new_entry;
        end else begin
          entry_d = left_i;
        end
      end
      OpDecrement: begin
        if (entry_q.valid) begin
          if (entry_q.slack <= SlackBits'(1)) begin
            entry_d.valid = 1'b0;
          end else begin
            entry_d.slack = entry_q.slack - SlackBits'(1);
          end
        end
      end
      OpCompact: begin
        if (!entry_q.valid && right_i.valid) begin
          entry_d = right_i;
        end else if (entry_q.valid && !left_i.valid) begin
          entry_d.valid = 1'b0;
        end
      end
      OpPop: entry_d = right_i;
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= entry_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= entry_d.value;
    slack_q <= entry_d.slack;
  end

  assign entry_o = entry_q;
  assign lower_o = entry_q.valid && (entry_q.value < ctl_i.value);
  assign gap_o   = !entry_q.valid && right_i.valid;
  assign bnd_o   = left_i.valid && !entry_q.valid;

endmodule

@@ src/bdvb_chain.sv @@
// Row of entry cells, kept sorted from highest entry at the head to lowest at the tail.
module bdvb_chain (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bdvb_pkg::cell_ctl_t   ctl_i,
  output bdvb_pkg::chain_stat_t stat_o
);
  import bdvb_pkg::*;

  entry_t                 cells[BufferDepth];
  logic [BufferDepth-1:0] lower_vec;
  logic [BufferDepth-1:0] gap_vec;
  logic [BufferDepth-1:0] bnd_vec;
  logic [OccW-1:0]        occ;

  for (genvar g = 0; g < BufferDepth; g++) begin : g_cell
    entry_t left, right;
    if (g == 0) begin : g_head
      assign left = EntryTop;
    end else begin : g_mid
      assign left = cells[g-1];
    end
    if (g == BufferDepth - 1) begin : g_tail
      assign right = EntryNone;
    end else begin : g_body
      assign right = cells[g+1];
    end
    bdvb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .left_i  (left),
      .right_i (right),
      .entry_o (cells[g]),
      .lower_o (lower_vec[g]),
      .gap_o   (gap_vec[g]),
      .bnd_o   (bnd_vec[g])
    );
  end

  always_comb begin
    occ = '0;
    for (int i = 0; i < BufferDepth; i++) begin
      if (bnd_vec[i]) begin
        occ = occ | OccW'(i);
      end
    end
    if (cells[BufferDepth-1].valid) begin
      occ = occ | OccW'(BufferDepth);
    end
  end

  assign stat_o.any_lower  = |lower_vec;
  assign stat_o.any_gap    = |gap_vec;
  assign stat_o.head_valid = cells[0].valid;
  assign stat_o.head_value = cells[0].value;
  assign stat_o.occ_found  = occ;

endmodule

@@ src/bdvb_ctrl.sv @@
// Sequencer that steps the cell chain through arrivals and ticks and keeps the totals.
module bdvb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type_i,
  input  logic [7:0]            copy_count_i,
  input  logic [7:0]            pkt_slack_i,
  input  logic [15:0]           pkt_value_i,
  input  logic                  cfg_we_i,
  input  logic [4:0]            cfg_wdata_i,
  input  bdvb_pkg::chain_stat_t stat_i,
  output bdvb_pkg::cell_ctl_t   ctl_o,
  output logic                  done_o,
  output logic                  sent_o,
  output logic [15:0]           sent_value_o,
  output logic [7:0]            dropped_now_o,
  output logic [4:0]            occupancy_o,
  output logic [31:0]           total_arrived_o,
  output logic [31:0]           total_dropped_o,
  output logic [31:0]           total_sent_o,
  output logic [47:0]           total_sent_value_o
);
  import bdvb_pkg::*;

  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StInsert  = 5'b00010,
    StDecr    = 5'b00100,
    StCompact = 5'b01000,
    StPop     = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [7:0]           copies_q, copies_d;
  logic [ValueBits-1:0] val_q, val_d;
  logic [SlackBits-1:0] slack_q, slack_d;
  logic [OccW-1:0]      occ_q, occ_d;
  logic [4:0]           cap_q;
  logic [DropW-1:0]     drops_q, drops_d;
  logic                 sent_q, sent_d;
  logic [ValueBits-1:0] sent_value_q, sent_value_d;
  logic [31:0]          arrived_q, arrived_d;
  logic [31:0]          dropped_q, dropped_d;
  logic [31:0]          sent_total_q, sent_total_d;
  logic [47:0]          sent_value_total_q, sent_value_total_d;
  logic                 done_q, done_d;
  cell_op_e             op;
  logic                 fin;
  logic                 has_room;

  assign has_room = (CmpW'(occ_q) < CmpW'(cap_q)) && (occ_q != OccW'(BufferDepth));

  always_comb begin
    state_d            = state_q;
    copies_d           = copies_q;
    val_d              = val_q;
    slack_d            = slack_q;
    occ_d              = occ_q;
    drops_d            = drops_q;
    sent_d             = sent_q;
    sent_value_d       = sent_value_q;
    arrived_d          = arrived_q;
    dropped_d          = dropped_q;
    sent_total_d       = sent_total_q;
    sent_value_total_d = sent_value_total_q;
    done_d             = 1'b0;
    op                 = OpHold;
    fin                = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          drops_d      = '0;
          sent_d       = 1'b0;
          sent_value_d = '0;
          if (req_type_i == ReqTick) begin
            state_d = StDecr;
          end else begin
            copies_d  = copy_count_i;
            val_d     = ValueBits'(pkt_value_i);
            slack_d   = SlackBits'(pkt_slack_i);
            arrived_d = sat_add32(arrived_q, 32'(copy_count_i));
            state_d   = StInsert;
          end
        end
      end
      StInsert: begin
        if (copies_q == '0) begin
          fin = 1'b1;
        end else if (cap_q == '0) begin
          drops_d = drops_q + DropW'(copies_q);
          fin     = 1'b1;
        end else if (has_room) begin
          op       = OpInsert;
          occ_d    = occ_q + OccW'(1);
          copies_d = copies_q - 8'd1;
        end else if (stat_i.any_lower) begin
          op       = OpReplace;
          drops_d  = drops_q + DropW'(1);
          copies_d = copies_q - 8'd1;
        end else begin
          drops_d = drops_q + DropW'(copies_q);
          fin     = 1'b1;
        end
      end
      StDecr: begin
        op      = OpDecrement;
        state_d = StCompact;
      end
      StCompact: begin
        if (stat_i.any_gap) begin
          op = OpCompact;
        end else begin
          drops_d = DropW'(occ_q) - DropW'(stat_i.occ_found);
          occ_d   = stat_i.occ_found;
          state_d = StPop;
        end
      end
      StPop: begin
        if (stat_i.head_valid) begin
          op                 = OpPop;
          sent_d             = 1'b1;
          sent_value_d       = stat_i.head_value;
          occ_d              = occ_q - OccW'(1);
          sent_total_d       = sat_add32(sent_total_q, 32'd1);
          sent_value_total_d = sat_add48(sent_value_total_q, 48'(stat_i.head_value));
        end
        fin = 1'b1;
      end
      default: state_d = StIdle;
    endcase
    if (fin) begin
      dropped_d = sat_add32(dropped_q, 32'(drops_d));
      done_d    = 1'b1;
      state_d   = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= StIdle;
      copies_q           <= '0;
      occ_q              <= '0;
      cap_q              <= 5'd16;
      drops_q            <= '0;
      sent_q             <= 1'b0;
      sent_value_q       <= '0;
      arrived_q          <= '0;
      dropped_q          <= '0;
      sent_total_q       <= '0;
      sent_value_total_q <= '0;
      done_q             <= 1'b0;
    end else begin
      state_q            <= state_d;
      copies_q           <= copies_d;
      occ_q              <= occ_d;
      drops_q            <= drops_d;
      sent_q             <= sent_d;
      sent_value_q       <= sent_value_d;
      arrived_q          <= arrived_d;
      dropped_q          <= dropped_d;
      sent_total_q       <= sent_total_d;
      sent_value_total_q <= sent_value_total_d;
      done_q             <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    slack_q <= slack_d;
  end

  assign busy               = (state_q != StIdle);
  assign ctl_o.op           = op;
  assign ctl_o.value        = val_q;
  assign ctl_o.slack        = slack_q;
  assign done_o             = done_q;
  assign sent_o             = sent_q;
  assign sent_value_o       = 16'(sent_value_q);
  assign dropped_now_o      = (drops_q > DropW'(255)) ? 8'hFF : drops_q[7:0];
  assign occupancy_o        = 5'(occ_q);
  assign total_arrived_o    = arrived_q;
  assign total_dropped_o    = dropped_q;
  assign total_sent_o       = sent_total_q;
  assign total_sent_value_o = sent_value_total_q;

endmodule

@@ src/bounded_delay_value_buffer.sv @@
// Top level of the bounded-delay value buffer: sequencer and sorted cell chain.
//
// Holds up to 16 valued packets with deadlines in a chain of cells sorted from the
// highest entry to the lowest. A word is taken when start is high and busy is low;
// its single result appears for one cycle with done_o high and cannot be held off,
// so it must be captured in that cycle. An arrival word stores one copy per cycle
// and keeps busy high until all its copies are stored or the rest are refused. A
// tick word steps the chain through a decrement, compaction passes of the chain
// until no gap is left, and a pop; expired entries close up one cell per pass.
// The capacity register may be written only while busy is low.
module bounded_delay_value_buffer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        req_type_i,
  input  logic [7:0]  copy_count_i,
  input  logic [7:0]  pkt_slack_i,
  input  logic [15:0] pkt_value_i,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  output logic        done_o,
  output logic        sent_o,
  output logic [15:0] sent_value_o,
  output logic [7:0]  dropped_now_o,
  output logic [4:0]  occupancy_o,
  output logic [31:0] total_arrived_o,
  output logic [31:0] total_dropped_o,
  output logic [31:0] total_sent_o,
  output logic [47:0] total_sent_value_o
);
  import bdvb_pkg::*;

  cell_ctl_t   ctl;
  chain_stat_t stat;

  bdvb_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .req_type_i         (req_type_i),
    .copy_count_i       (copy_count_i),
    .pkt_slack_i        (pkt_slack_i),
    .pkt_value_i        (pkt_value_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .stat_i             (stat),
    .ctl_o              (ctl),
    .done_o             (done_o),
    .sent_o             (sent_o),
    .sent_value_o       (sent_value_o),
    .dropped_now_o      (dropped_now_o),
    .occupancy_o        (occupancy_o),
    .total_arrived_o    (total_arrived_o),
    .total_dropped_o    (total_dropped_o),
    .total_sent_o       (total_sent_o),
    .total_sent_value_o (total_sent_value_o)
  );

  bdvb_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .stat_o (stat)
  );

`ifndef SYNTHESIS
  a_busy_after_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy did not rise after a word was taken");

  a_done_when_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_sent_counted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && sent_o) |-> (total_sent_o != 32'd0))
    else $error("packet sent but sent total is zero");

  a_occ_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (occupancy_o <= 5'(BufferDepth)))
    else $error("occupancy beyond buffer depth");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench of the bounded-delay value buffer, with its own prediction of each result.
`timescale 1ns / 1ps

module tb_top;
  import bdvb_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int TailCycles    = 300;

  typedef struct packed {
    req_e       kind;
    logic [7:0] copies;
    logic [7:0] slack;
    logic [15:0] value;
  } pkt_word_t;

  typedef struct packed {
    logic        sent;
    logic [15:0] sent_value;
    logic [7:0]  dropped_now;
    logic [4:0]  occupancy;
    logic [31:0] total_arrived;
    logic [31:0] total_dropped;
    logic [31:0] total_sent;
    logic [47:0] total_sent_value;
  } buf_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        req_type_i = 1'b0;
  logic [7:0]  copy_count_i = '0;
  logic [7:0]  pkt_slack_i = '0;
  logic [15:0] pkt_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        done_o;
  logic        sent_o;
  logic [15:0] sent_value_o;
  logic [7:0]  dropped_now_o;
  logic [4:0]  occupancy_o;
  logic [31:0] total_arrived_o;
  logic [31:0] total_dropped_o;
  logic [31:0] total_sent_o;
  logic [47:0] total_sent_value_o;

  pkt_word_t   pending_words[$];
  buf_result_t expected_results[$];
  pkt_word_t   shown_word;
  int          sender_idle_pct = 38;
  int          fail_count = 0;
  int          quiet_cycles = 0;

  logic [15:0] held_value[BufferDepth];
  logic [7:0]  held_slack[BufferDepth];
  bit          held_valid[BufferDepth];
  logic [31:0] arrived_cnt = '0;
  logic [31:0] dropped_cnt = '0;
  logic [31:0] sent_cnt = '0;
  logic [47:0] sent_value_sum = '0;
  logic [4:0]  buf_capacity = 5'd16;

  bounded_delay_value_buffer u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .req_type_i         (req_type_i),
    .copy_count_i       (copy_count_i),
    .pkt_slack_i        (pkt_slack_i),
    .pkt_value_i        (pkt_value_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .done_o             (done_o),
    .sent_o             (sent_o),
    .sent_value_o       (sent_value_o),
    .dropped_now_o      (dropped_now_o),
    .occupancy_o        (occupancy_o),
    .total_arrived_o    (total_arrived_o),
    .total_dropped_o    (total_dropped_o),
    .total_sent_o       (total_sent_o),
    .total_sent_value_o (total_sent_value_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int held_count();
    int n;
    n = 0;
    for (int i = 0; i < BufferDepth; i++) begin
      if (held_valid[i]) n++;
    end
    return n;
  endfunction

  function automatic bit ranks_below(input int a, input int b);
    if (held_value[a] != held_value[b]) return held_value[a] < held_value[b];
    return held_slack[a] < held_slack[b];
  endfunction

  function automatic buf_result_t predict_buffer_result(input pkt_word_t w);
    buf_result_t r;
    int          drops;
    int          cap;
    int          copies;
    int          slot;
    int          lo;
    int          hi;
    logic [32:0] sum33;
    logic [48:0] sum49;
    r = '0;
    drops = 0;
    cap = (buf_capacity > BufferDepth) ? BufferDepth : int'(buf_capacity);
    if (w.kind == ReqArrival) begin
      copies = int'(w.copies);
      sum33 = {1'b0, arrived_cnt} + 33'(w.copies);
      arrived_cnt = sum33[32] ? '1 : sum33[31:0];
      while (copies > 0) begin
        slot = BufferDepth;
        if (cap == 0) begin
          drops += copies;
          break;
        end
        if (held_count() < cap) begin
          for (int i = BufferDepth - 1; i >= 0; i--) begin
            if (!held_valid[i]) slot = i;
          end
        end else begin
          lo = BufferDepth;
          for (int i = 0; i < BufferDepth; i++) begin
            if (held_valid[i] && (lo == BufferDepth || ranks_below(i, lo))) lo = i;
          end
          if (lo < BufferDepth && w.value > held_value[lo]) begin
            slot = lo;
            drops++;
          end
        end
        if (slot >= BufferDepth) begin
          drops += copies;
          break;
        end
        held_value[slot] = w.value;
        held_slack[slot] = w.slack;
        held_valid[slot] = 1'b1;
        copies--;
      end
    end else begin
      hi = BufferDepth;
      for (int i = 0; i < BufferDepth; i++) begin
        if (held_valid[i]) begin
          if (held_slack[i] <= 8'd1) begin
            held_valid[i] = 1'b0;
            drops++;
          end else begin
            held_slack[i] = held_slack[i] - 8'd1;
          end
        end
      end
      for (int i = 0; i < BufferDepth; i++) begin
        if (held_valid[i] && (hi == BufferDepth || ranks_below(hi, i))) hi = i;
      end
      if (hi < BufferDepth) begin
        r.sent = 1'b1;
        r.sent_value = held_value[hi];
        held_valid[hi] = 1'b0;
        sum33 = {1'b0, sent_cnt} + 33'd1;
        sent_cnt = sum33[32] ? '1 : sum33[31:0];
        sum49 = {1'b0, sent_value_sum} + 49'(held_value[hi]);
        sent_value_sum = sum49[48] ? '1 : sum49[47:0];
      end
    end
    sum33 = {1'b0, dropped_cnt} + 33'(drops);
    dropped_cnt = sum33[32] ? '1 : sum33[31:0];
    r.dropped_now = (drops > 255) ? 8'd255 : 8'(drops);
    r.occupancy = 5'(held_count());
    r.total_arrived = arrived_cnt;
    r.total_dropped = dropped_cnt;
    r.total_sent = sent_cnt;
    r.total_sent_value = sent_value_sum;
    return r;
  endfunction

  function automatic pkt_word_t random_word();
    pkt_word_t w;
    int        pick;
    w.kind = ($urandom_range(99) < 55) ? ReqArrival : ReqTick;
    pick = $urandom_range(99);
    if (pick < 5) w.copies = 8'd0;
    else if (pick < 75) w.copies = 8'($urandom_range(1, 6));
    else if (pick < 93) w.copies = 8'($urandom_range(7, 40));
    else w.copies = 8'($urandom_range(41, 255));
    pick = $urandom_range(99);
    if (pick < 70) w.slack = 8'($urandom_range(0, 6));
    else if (pick < 90) w.slack = 8'($urandom_range(7, 40));
    else w.slack = 8'($urandom_range(0, 255));
    pick = $urandom_range(99);
    if (pick < 50) w.value = 16'($urandom_range(0, 7));
    else if (pick < 60) w.value = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    else w.value = 16'($urandom_range(0, 65535));
    return w;
  endfunction

  function automatic void queue_word(input req_e kind, input logic [7:0] copies,
                                     input logic [7:0] slack, input logic [15:0] value);
    pending_words.push_back('{kind: kind, copies: copies, slack: slack, value: value});
  endfunction

  function automatic void check_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic wait_drained();
    while (pending_words.size() != 0 || start || busy || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [4:0] c);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c;
    buf_capacity = c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Sender: presents one word at a time and predicts its result when it is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) expected_results.push_back(predict_buffer_result(shown_word));
      if (!start || !busy) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          shown_word = pending_words.pop_front();
          start <= 1'b1;
          req_type_i <= shown_word.kind;
          copy_count_i <= shown_word.copies;
          pkt_slack_i <= shown_word.slack;
          pkt_value_i <= shown_word.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    buf_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $error("result word arrived with no expectation pending");
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("sent", 48'(want.sent), 48'(sent_o));
        check_field("sent_value", 48'(want.sent_value), 48'(sent_value_o));
        check_field("dropped_now", 48'(want.dropped_now), 48'(dropped_now_o));
        check_field("occupancy", 48'(want.occupancy), 48'(occupancy_o));
        check_field("total_arrived", 48'(want.total_arrived), 48'(total_arrived_o));
        check_field("total_dropped", 48'(want.total_dropped), 48'(total_dropped_o));
        check_field("total_sent", 48'(want.total_sent), 48'(total_sent_o));
        check_field("total_sent_value", want.total_sent_value, total_sent_value_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [4:0] seg_cap[9];
    for (int i = 0; i < BufferDepth; i++) held_valid[i] = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Capacity above the built depth, then the edges of each field.
    set_capacity(5'd31);
    queue_word(ReqTick, 8'd0, 8'd0, 16'd0);
    queue_word(ReqArrival, 8'd1, 8'd0, 16'h0000);
    queue_word(ReqArrival, 8'd0, 8'd5, 16'd9);
    queue_word(ReqTick, 8'd0, 8'd0, 16'd0);
    queue_word(ReqArrival, 8'd1, 8'd0, 16'h0000);
    queue_word(ReqArrival, 8'd255, 8'hFF, 16'hFFFF);
    queue_word(ReqArrival, 8'd3, 8'd3, 16'hFFFF);
    queue_word(ReqTick, 8'hFF, 8'hFF, 16'hFFFF);
    queue_word(ReqArrival, 8'd1, 8'd1, 16'h8000);
    queue_word(ReqArrival, 8'd2, 8'd7, 16'h0001);
    queue_word(ReqTick, 8'd0, 8'd0, 16'd0);

    // Capacity lowered below the occupancy: the buffer counts as full.
    set_capacity(5'd1);
    queue_word(ReqArrival, 8'd4, 8'd2, 16'd7);
    queue_word(ReqTick, 8'd0, 8'd0, 16'd0);

    // Zero capacity refuses every copy.
    set_capacity(5'd0);
    queue_word(ReqArrival, 8'd255, 8'd0, 16'd0);
    queue_word(ReqArrival, 8'd0, 8'd1, 16'd1);
    queue_word(ReqTick, 8'd0, 8'd0, 16'd0);

    // Ties on value, broken by slack.
    set_capacity(5'd2);
    queue_word(ReqArrival, 8'd1, 8'd4, 16'd3);
    queue_word(ReqArrival, 8'd1, 8'd9, 16'd3);
    queue_word(ReqArrival, 8'd1, 8'd6, 16'd4);
    queue_word(ReqTick, 8'd0, 8'd0, 16'd0);
    queue_word(ReqTick, 8'd0, 8'd0, 16'd0);
    queue_word(ReqTick, 8'd0, 8'd0, 16'd0);

    seg_cap[0] = 5'd16;
    seg_cap[1] = 5'd1;
    seg_cap[2] = 5'($urandom_range(2, 15));
    seg_cap[3] = 5'd0;
    seg_cap[4] = 5'd31;
    seg_cap[5] = 5'd3;
    seg_cap[6] = 5'($urandom_range(0, 31));
    seg_cap[7] = 5'd16;
    seg_cap[8] = 5'd8;
    for (int seg = 0; seg < 9; seg++) begin
      set_capacity(seg_cap[seg]);
      sender_idle_pct = (seg < 3) ? 38 : ((seg < 6) ? 84 : 0);
      repeat (50) pending_words.push_back(random_word());
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
